// ----- hdl/kfts_pkg.sv -----
package kfts_pkg;

    // One key as it sits in the key memory.
    typedef struct packed {
        logic [31:0] time_q;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } key_t;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_SRCH = 12'b0000_0000_0010,
        ST_LDA  = 12'b0000_0000_0100,
        ST_LDB  = 12'b0000_0000_1000,
        ST_PREP = 12'b0000_0001_0000,
        ST_OVF  = 12'b0000_0010_0000,
        ST_DIV  = 12'b0000_0100_0000,
        ST_FCT  = 12'b0000_1000_0000,
        ST_BDIF = 12'b0001_0000_0000,
        ST_BMUL = 12'b0010_0000_0000,
        ST_BADD = 12'b0100_0000_0000,
        ST_DONE = 12'b1000_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        COMP_X = 2'd0,
        COMP_Y = 2'd1,
        COMP_Z = 2'd2
    } comp_t;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Blend factor is signed Q4.16, held in 20 bits.
    localparam int unsigned FACT_W    = 20;
    localparam int unsigned DIV_STEPS = 20;
    localparam int unsigned CNT_W     = 5;

    localparam logic [FACT_W-1:0] FACT_MAX = 20'h7FFFF;
    localparam logic [FACT_W-1:0] FACT_MIN = 20'h80000;

    localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;

endpackage

// ----- hdl/kfts_key_mem.sv -----
module kfts_key_mem
    import kfts_pkg::*;
#(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  key_t          wr_key,
    input  logic [AW-1:0] rd_addr,
    output key_t          rd_key
);

    key_t mem [DEPTH];
    key_t rd_key_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_key;
        end
        rd_key_reg <= mem[rd_addr];
    end

    assign rd_key = rd_key_reg;

endmodule

// ----- hdl/keyframe_track_sampler_unit.sv -----
// Keyframe track sampler with linear interpolation over up to MAX_KEYS xyz keys. A load item
// writes one key. A query item walks the key memory one key per cycle
// to find its segment, runs a 20-step restoring divider for the Q4.16 blend factor and
// then blends x, y and z through one shared multiplier, in a difference, a multiply and an
// add step per component. The search through the single-read key memory and the divider
// set how long a query takes, and the divider is cut short when the quotient reaches 2^20.
// One item is in work at a time; a finished result waits in the output register while the
// next item is accepted.
module keyframe_track_sampler_unit
    import kfts_pkg::*;
#(
    parameter int unsigned MAX_KEYS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [4:0]         s_key_slot,
    input  logic [31:0]        s_key_time,
    input  logic signed [31:0] s_key_x,
    input  logic signed [31:0] s_key_y,
    input  logic signed [31:0] s_key_z,
    input  logic [31:0]        s_query_time,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_value_x,
    output logic signed [31:0] m_value_y,
    output logic signed [31:0] m_value_z,
    output logic [4:0]         m_segment,
    output logic               m_past_end,

    input  logic               cfg_we,
    input  logic [5:0]         cfg_wdata
);

    localparam int unsigned IDXW = $clog2(MAX_KEYS);
    localparam int unsigned CNTW = $clog2(MAX_KEYS + 1);
    localparam int unsigned CMPW = (CNTW > 6) ? CNTW : 6;
    localparam int unsigned SW   = (CNTW > 5) ? CNTW : 5;

    state_t state_reg, state_next;

    logic [5:0]        key_count_reg;
    logic [31:0]       t_reg;
    logic [IDXW-1:0]   idx_reg;
    logic [IDXW-1:0]   rd_idx_reg;
    logic              rd_pend_reg;
    logic [IDXW-1:0]   last_reg;
    logic [IDXW-1:0]   seg_reg;
    logic              past_reg;

    logic [31:0]       t0_reg, t1_reg;
    logic [31:0]       ax_reg, ay_reg, az_reg;
    logic [31:0]       bx_reg, by_reg, bz_reg;

    logic              neg_reg;
    logic [31:0]       mag_reg;
    logic [31:0]       span_reg;
    logic              ovf_reg;
    logic [31:0]       rem_reg;
    logic [FACT_W-1:0] dvd_reg;
    logic [FACT_W-1:0] q_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic signed [FACT_W-1:0] f_reg;

    comp_t             comp_reg;
    logic signed [32:0] diff_reg;
    logic signed [52:0] prod_reg;

    logic              m_valid_reg;
    logic [31:0]       m_x_reg, m_y_reg, m_z_reg;
    logic [4:0]        m_seg_reg;
    logic              m_past_reg;

    // Memory ports.
    logic              mem_we;
    logic [SW-1:0]     slot_ext;
    logic [IDXW-1:0]   mem_rd_addr;
    key_t              mem_wr_key;
    key_t              rd_key;

    // Effective key count and last index.
    logic [CMPW-1:0]   kc_ext;
    logic [CNTW-1:0]   n_eff;
    logic [IDXW-1:0]   last_c;

    // Arithmetic.
    logic [32:0]       num_c, span_c;
    logic [31:0]       mag_c, span_fl;
    logic [32:0]       div_trial, div_diff;
    logic              div_ge;
    logic [31:0]       a_sel, b_sel;
    logic signed [37:0] sum_c;
    logic [31:0]       sat_c;
    logic [SW-1:0]     seg_ext;
    logic              out_free;
    logic              accept;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // ---------------- key memory ----------------
    assign slot_ext   = SW'(s_key_slot);
    assign mem_we     = accept && (s_action == ACT_LOAD) && (slot_ext < SW'(MAX_KEYS));
    assign mem_wr_key = '{time_q: s_key_time, x: s_key_x, y: s_key_y, z: s_key_z};
    assign mem_rd_addr = (state_reg == ST_LDA) ? seg_reg : idx_reg;

    kfts_key_mem #(
        .DEPTH (MAX_KEYS),
        .AW    (IDXW)
    ) u_key_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (slot_ext[IDXW-1:0]),
        .wr_key  (mem_wr_key),
        .rd_addr (mem_rd_addr),
        .rd_key  (rd_key)
    );

    // ---------------- combinational helpers ----------------
    always_comb begin
        kc_ext = CMPW'(key_count_reg);
        if (kc_ext == '0) begin
            n_eff = CNTW'(1);
        end else if (kc_ext > CMPW'(MAX_KEYS)) begin
            n_eff = CNTW'(MAX_KEYS);
        end else begin
            n_eff = CNTW'(kc_ext);
        end
        last_c = IDXW'(n_eff - CNTW'(1));
    end

    always_comb begin
        num_c  = {1'b0, t_reg} - {1'b0, t0_reg};
        mag_c  = num_c[32] ? (~num_c[31:0] + 32'd1) : num_c[31:0];
        span_c = {1'b0, t1_reg} - {1'b0, t0_reg};
        // A zero or negative span (repeated or unordered keys) is floored at one LSB.
        span_fl = (span_c[32] || (span_c == '0)) ? 32'd1 : span_c[31:0];
    end

    assign div_trial = {rem_reg, dvd_reg[FACT_W-1]};
    assign div_ge    = div_trial >= {1'b0, span_reg};
    assign div_diff  = div_trial - {1'b0, span_reg};

    always_comb begin
        case (comp_reg)
            COMP_X: begin
                a_sel = ax_reg;
                b_sel = bx_reg;
            end
            COMP_Y: begin
                a_sel = ay_reg;
                b_sel = by_reg;
            end
            default: begin
                a_sel = az_reg;
                b_sel = bz_reg;
            end
        endcase
    end

    // The upper product bits are the floor of the product over 2^16.
    always_comb begin
        sum_c = {{6{a_sel[31]}}, a_sel} + {prod_reg[52], prod_reg[52:16]};
        if (sum_c[37:31] == '0 || sum_c[37:31] == '1) begin
            sat_c = sum_c[31:0];
        end else begin
            sat_c = sum_c[37] ? VAL_MIN : VAL_MAX;
        end
    end

    assign seg_ext = SW'(seg_reg);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_action == ACT_QUERY) begin
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (rd_pend_reg) begin
                    if (last_reg == '0 || rd_idx_reg == last_reg) begin
                        state_next = (last_reg != '0 && t_reg <= rd_key.time_q) ?
                                     ST_LDA : ST_DONE;
                    end else if (t_reg <= rd_key.time_q) begin
                        state_next = ST_LDA;
                    end
                end
            end
            ST_LDA:  state_next = ST_LDB;
            ST_LDB:  state_next = ST_PREP;
            ST_PREP: state_next = ST_OVF;
            ST_OVF:  state_next = ST_DIV;
            ST_DIV: begin
                if (ovf_reg || cnt_reg == CNT_W'(1)) begin
                    state_next = ST_FCT;
                end
            end
            ST_FCT:  state_next = ST_BDIF;
            ST_BDIF: state_next = ST_BMUL;
            ST_BMUL: state_next = ST_BADD;
            ST_BADD: begin
                if (comp_reg == COMP_Z) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_BDIF;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            key_count_reg <= 6'd1;
            m_valid_reg   <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                key_count_reg <= cfg_wdata;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            rd_pend_reg <= (state_reg == ST_SRCH);
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                t_reg    <= s_query_time;
                last_reg <= last_c;
                // A one-key track reads key 0; otherwise the search starts at key 1.
                idx_reg  <= (last_c == '0) ? '0 : IDXW'(1);
                comp_reg <= COMP_X;
            end
            ST_SRCH: begin
                rd_idx_reg <= idx_reg;
                idx_reg    <= idx_reg + IDXW'(1);
                ax_reg     <= rd_key.x;
                ay_reg     <= rd_key.y;
                az_reg     <= rd_key.z;
                bx_reg     <= rd_key.x;
                by_reg     <= rd_key.y;
                bz_reg     <= rd_key.z;
                t1_reg     <= rd_key.time_q;
                if (last_reg == '0) begin
                    seg_reg  <= '0;
                    past_reg <= 1'b0;
                end else if (t_reg <= rd_key.time_q) begin
                    seg_reg  <= rd_idx_reg - IDXW'(1);
                    past_reg <= 1'b0;
                end else begin
                    seg_reg  <= rd_idx_reg;
                    past_reg <= 1'b1;
                end
            end
            ST_LDB: begin
                t0_reg <= rd_key.time_q;
                ax_reg <= rd_key.x;
                ay_reg <= rd_key.y;
                az_reg <= rd_key.z;
            end
            ST_PREP: begin
                neg_reg  <= num_c[32];
                mag_reg  <= mag_c;
                span_reg <= span_fl;
            end
            ST_OVF: begin
                // A quotient of 2^20 or more saturates whatever its sign.
                ovf_reg <= {4'b0, mag_reg} >= {span_reg, 4'b0};
                rem_reg <= {4'b0, mag_reg[31:4]};
                dvd_reg <= {mag_reg[3:0], 16'b0};
                q_reg   <= '0;
                cnt_reg <= CNT_W'(DIV_STEPS);
            end
            ST_DIV: begin
                rem_reg <= div_ge ? div_diff[31:0] : div_trial[31:0];
                q_reg   <= {q_reg[FACT_W-2:0], div_ge};
                dvd_reg <= {dvd_reg[FACT_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            ST_FCT: begin
                if (neg_reg) begin
                    f_reg <= (ovf_reg || q_reg > FACT_MIN) ? FACT_MIN : (~q_reg + FACT_W'(1));
                end else begin
                    f_reg <= (ovf_reg || q_reg > FACT_MAX) ? FACT_MAX : q_reg;
                end
            end
            ST_BDIF: begin
                diff_reg <= {b_sel[31], b_sel} - {a_sel[31], a_sel};
            end
            ST_BMUL: begin
                prod_reg <= diff_reg * f_reg;
            end
            ST_BADD: begin
                case (comp_reg)
                    COMP_X: begin
                        ax_reg   <= sat_c;
                        comp_reg <= COMP_Y;
                    end
                    COMP_Y: begin
                        ay_reg   <= sat_c;
                        comp_reg <= COMP_Z;
                    end
                    default: begin
                        az_reg   <= sat_c;
                        comp_reg <= COMP_X;
                    end
                endcase
            end
            ST_DONE: begin
                if (out_free) begin
                    m_x_reg    <= ax_reg;
                    m_y_reg    <= ay_reg;
                    m_z_reg    <= az_reg;
                    m_seg_reg  <= seg_ext[4:0];
                    m_past_reg <= past_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_value_x  = m_x_reg;
    assign m_value_y  = m_y_reg;
    assign m_value_z  = m_z_reg;
    assign m_segment  = m_seg_reg;
    assign m_past_end = m_past_reg;

endmodule

// ----- tb/testbench.sv -----
module testbench;
    import kfts_pkg::*;

    localparam int KEY_SLOTS   = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int IDLE_GAP    = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int PRINT_CAP   = 40;

    localparam longint FAC_HI = 524287;
    localparam longint FAC_LO = -524288;
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic               action;
        logic [4:0]         slot;
        logic [31:0]        key_time;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        query_time;
    } key_item_t;

    typedef struct packed {
        logic signed [31:0] value_x;
        logic signed [31:0] value_y;
        logic signed [31:0] value_z;
        logic [4:0]         segment;
        logic               past_end;
    } sample_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_action = ACT_LOAD;
    logic [4:0]         s_key_slot = '0;
    logic [31:0]        s_key_time = '0;
    logic signed [31:0] s_key_x = '0;
    logic signed [31:0] s_key_y = '0;
    logic signed [31:0] s_key_z = '0;
    logic [31:0]        s_query_time = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_value_x;
    logic signed [31:0] m_value_y;
    logic signed [31:0] m_value_z;
    logic [4:0]         m_segment;
    logic               m_past_end;
    logic               cfg_we = 1'b0;
    logic [5:0]         cfg_wdata = '0;

    // Track copy used for prediction, updated as items are accepted.
    logic [31:0]        trk_time [KEY_SLOTS];
    logic signed [31:0] trk_x [KEY_SLOTS];
    logic signed [31:0] trk_y [KEY_SLOTS];
    logic signed [31:0] trk_z [KEY_SLOTS];
    logic [5:0]         track_count = 6'd1;

    // Key times as the stimulus has laid them out, used to aim query times.
    logic [31:0]        gen_time [KEY_SLOTS];

    key_item_t key_items[$];
    sample_t   pending_samples[$];
    key_item_t cur_item = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit hold_armed = 1'b0;
    bit hold_used = 1'b0;

    keyframe_track_sampler_unit #(.MAX_KEYS(KEY_SLOTS)) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_key_slot   (s_key_slot),
        .s_key_time   (s_key_time),
        .s_key_x      (s_key_x),
        .s_key_y      (s_key_y),
        .s_key_z      (s_key_z),
        .s_query_time (s_query_time),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value_x    (m_value_x),
        .m_value_y    (m_value_y),
        .m_value_z    (m_value_z),
        .m_segment    (m_segment),
        .m_past_end   (m_past_end),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP) begin
            $display("ERROR cycle %0d: %s", cycle_count, what);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
        end
    endtask

    function automatic logic [31:0] blend_comp(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input longint fac);
        longint la;
        longint lb;
        longint r;
        la = a;
        lb = b;
        // Arithmetic shift of a signed product rounds toward minus infinity.
        r = la + (((lb - la) * fac) >>> 16);
        if (r > S32_HI) begin
            r = S32_HI;
        end
        if (r < S32_LO) begin
            r = S32_LO;
        end
        return r[31:0];
    endfunction

    function automatic sample_t sample_track(input logic [31:0] t);
        sample_t r;
        int      n;
        int      seg;
        int      i;
        bit      hit;
        longint  t_l;
        longint  t0_l;
        longint  t1_l;
        longint  num;
        longint  span;
        longint  mag;
        longint  q;
        longint  fac;
        r = '0;
        if (track_count == 0) begin
            n = 1;
        end else if (track_count > KEY_SLOTS) begin
            n = KEY_SLOTS;
        end else begin
            n = track_count;
        end
        if (n == 1) begin
            r.value_x = trk_x[0];
            r.value_y = trk_y[0];
            r.value_z = trk_z[0];
            return r;
        end
        hit = 1'b0;
        seg = 0;
        for (i = 0; i + 1 < n && !hit; i++) begin
            if (t <= trk_time[i + 1]) begin
                seg = i;
                hit = 1'b1;
            end
        end
        if (!hit) begin
            r.value_x  = trk_x[n - 1];
            r.value_y  = trk_y[n - 1];
            r.value_z  = trk_z[n - 1];
            r.segment  = 5'(n - 1);
            r.past_end = 1'b1;
            return r;
        end
        t_l  = t;
        t0_l = trk_time[seg];
        t1_l = trk_time[seg + 1];
        num  = t_l - t0_l;
        span = t1_l - t0_l;
        if (span < 1) begin
            span = 1;
        end
        mag = (num < 0) ? -num : num;
        q   = (mag << 16) / span;
        if (num < 0) begin
            fac = (q > -FAC_LO) ? FAC_LO : -q;
        end else begin
            fac = (q > FAC_HI) ? FAC_HI : q;
        end
        r.value_x = blend_comp(trk_x[seg], trk_x[seg + 1], fac);
        r.value_y = blend_comp(trk_y[seg], trk_y[seg + 1], fac);
        r.value_z = blend_comp(trk_z[seg], trk_z[seg + 1], fac);
        r.segment = 5'(seg);
        return r;
    endfunction

    task automatic apply_item(input key_item_t it);
        if (it.action == ACT_LOAD) begin
            trk_time[it.slot] = it.key_time;
            trk_x[it.slot]    = it.x;
            trk_y[it.slot]    = it.y;
            trk_z[it.slot]    = it.z;
        end else begin
            pending_samples.push_back(sample_track(it.query_time));
        end
    endtask

    always @(posedge aclk) begin : drive_proc
        key_item_t nxt;
        bit        offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_item(cur_item);
            end
            if (!s_valid || s_ready) begin
                offer = key_items.size() != 0 && $urandom_range(99) >= send_idle_pct;
                if (offer) begin
                    nxt = key_items.pop_front();
                    cur_item     <= nxt;
                    s_action     <= nxt.action;
                    s_key_slot   <= nxt.slot;
                    s_key_time   <= nxt.key_time;
                    s_key_x      <= nxt.x;
                    s_key_y      <= nxt.y;
                    s_key_z      <= nxt.z;
                    s_query_time <= nxt.query_time;
                    s_valid      <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // A long receiver hold-off, counted here so the monitor only has to look at it.
    always @(posedge aclk) begin : hold_proc
        if (hold_armed && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin : watch_proc
        sample_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_samples.size() == 0) begin
                    report_mismatch("result with no query outstanding");
                end else begin
                    want = pending_samples.pop_front();
                    check_field("value_x", m_value_x, want.value_x);
                    check_field("value_y", m_value_y, want.value_y);
                    check_field("value_z", m_value_z, want.value_z);
                    check_field("segment", 32'(m_segment), 32'(want.segment));
                    check_field("past_end", 32'(m_past_end), 32'(want.past_end));
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : limit_proc
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            cycle_count <= cycle_count + 1;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3, 4: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_load(input int slot, input logic [31:0] t, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
        key_item_t it;
        it = '0;
        it.action   = ACT_LOAD;
        it.slot     = 5'(slot);
        it.key_time = t;
        it.x        = x;
        it.y        = y;
        it.z        = z;
        // Query time is a don't-care on loads; keep its bits moving anyway.
        it.query_time = $urandom;
        gen_time[slot] = t;
        key_items.push_back(it);
    endtask

    task automatic push_query(input logic [31:0] t);
        key_item_t it;
        it = '0;
        it.action     = ACT_QUERY;
        it.slot       = 5'($urandom_range(31));
        it.key_time   = $urandom;
        it.x          = $urandom;
        it.y          = $urandom;
        it.z          = $urandom;
        it.query_time = t;
        key_items.push_back(it);
    endtask

    // Wait until the block has drained, then let any trailing load finish.
    task automatic settle();
        while (key_items.size() != 0 || s_valid || pending_samples.size() != 0) begin
            @(negedge aclk);
        end
        repeat (IDLE_GAP) @(negedge aclk);
    endtask

    task automatic write_key_count(input logic [5:0] v);
        settle();
        @(posedge aclk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= v;
        track_count <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_idling(input idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SENDER) ? 58 : (mode == IDLE_BOTH) ? 13 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 58 : (mode == IDLE_BOTH) ? 13 : 0;
    endtask

    // Lay down keys 0..n-1, mostly ascending with uneven gaps, sometimes scrambled.
    task automatic lay_track(input int n);
        longint acc;
        bit     jumbled;
        int     i;
        jumbled = ($urandom_range(9) == 0);
        acc = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 32'h8000_0000);
        for (i = 0; i < n; i++) begin
            push_load(i, jumbled ? $urandom :
                      32'((acc > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc),
                      rand_coord(), rand_coord(), rand_coord());
            case ($urandom_range(9))
                0: acc += 0;
                1, 2: acc += $urandom_range(1, 256);
                3: acc += $urandom_range(0, 32'h1000_0000);
                default: acc += $urandom_range(1, 32'h0100_0000);
            endcase
        end
    endtask

    task automatic run_phase(input logic [5:0] count_val, input int n_items,
                             input idle_mode_t mode, input bit long_hold);
        int          n;
        int          pushed;
        int          slot;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] qt;
        write_key_count(count_val);
        set_idling(mode);
        n = (count_val == 0) ? 1 : (count_val > KEY_SLOTS) ? KEY_SLOTS : count_val;
        if (long_hold) begin
            hold_armed <= 1'b1;
        end
        lay_track(n);
        pushed = n;
        while (pushed < n_items) begin
            if ($urandom_range(99) < 25) begin
                slot = $urandom_range(31);
                if ($urandom_range(4) == 0 || slot >= n) begin
                    qt = $urandom;
                end else begin
                    lo = (slot == 0) ? 32'h0 : gen_time[slot - 1];
                    hi = (slot + 1 < n) ? gen_time[slot + 1] : 32'hFFFF_FFFF;
                    qt = $urandom_range(lo, hi);
                end
                push_load(slot, qt, rand_coord(), rand_coord(), rand_coord());
            end else begin
                case ($urandom_range(7))
                    0: qt = $urandom;
                    1: qt = gen_time[$urandom_range(n - 1)];
                    2: qt = gen_time[$urandom_range(n - 1)] + 32'd1;
                    3: qt = gen_time[$urandom_range(n - 1)] - 32'd1;
                    4: qt = $urandom_range(0, gen_time[0]);
                    5: qt = $urandom_range(gen_time[n - 1], 32'hFFFF_FFFF);
                    default: qt = $urandom_range(gen_time[0], gen_time[n - 1]);
                endcase
                push_query(qt);
            end
            pushed++;
        end
    endtask

    initial begin : stimulus
        int wait_left;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Single-key track: every query returns key 0.
        set_idling(IDLE_NONE);
        push_load(0, 32'h1000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        push_query(32'h0);
        push_query(32'hFFFF_FFFF);

        // Four keys with a zero-length middle segment and full-scale swings.
        write_key_count(6'd4);
        push_load(1, 32'h1000_8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_load(2, 32'h1000_8000, 32'h0, 32'h1, 32'hFFFF_FFFF);
        push_load(3, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_AAAA);
        push_load(31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        push_query(32'h0);
        push_query(32'h0FFF_FFFF);
        push_query(32'h1000_0000);
        push_query(32'h1000_4000);
        push_query(32'h1000_8000);
        push_query(32'h1000_8001);
        push_query(32'h8000_0000);
        push_query(32'hFFFF_FFFE);
        push_query(32'hFFFF_FFFF);
        // First key later than the second: the span floors at one tick.
        push_load(0, 32'h2000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
        push_query(32'h1000_0000);
        push_load(0, 32'h1000_8000, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
        push_query(32'h1000_8000);

        run_phase(6'd32, 135, IDLE_NONE, 1'b0);
        run_phase(6'd63, 135, IDLE_SENDER, 1'b0);
        run_phase(6'd0, 135, IDLE_RECEIVER, 1'b0);
        run_phase(6'd2, 135, IDLE_BOTH, 1'b0);
        run_phase(6'd17, 135, IDLE_NONE, 1'b1);
        run_phase(6'd5, 135, IDLE_SENDER, 1'b0);
        run_phase(6'd32, 135, IDLE_RECEIVER, 1'b0);
        run_phase(6'd9, 135, IDLE_BOTH, 1'b0);

        while (key_items.size() != 0 || s_valid) begin
            @(negedge aclk);
        end
        wait_left = 5000;
        while (pending_samples.size() != 0 && wait_left != 0) begin
            @(negedge aclk);
            wait_left--;
        end
        repeat (200) @(negedge aclk);
        if (pending_samples.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_samples.size()));
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- keyframe_track_sampler_unit.f -----
hdl/kfts_pkg.sv
hdl/kfts_key_mem.sv
hdl/keyframe_track_sampler_unit.sv
tb/testbench.sv
